// ===== rtl/pwm_shadow_duty_flush_top_assert.svh =====
// Assertion macros used by the checker file of the PWM shadow duty block.
// Needs nothing else; include by bare file name.
`ifndef PWM_SHADOW_DUTY_FLUSH_TOP_ASSERT_SVH
`define PWM_SHADOW_DUTY_FLUSH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PSDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/psdf_pkg.sv =====
// Shared types, constants and the write encoder of the PWM shadow duty block.
// No dependencies.
package psdf_pkg;

    localparam int CHANNELS   = 16;
    localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PHASE_STEP = 4096 / CHANNELS;

    localparam logic [11:0] DUTY_MAX  = 12'h0FFF;
    localparam logic [12:0] FULL_FLAG = 13'd4096;

    localparam logic [1:0] MODE_SET     = 2'd0;
    localparam logic [1:0] MODE_SET_ALL = 2'd1;
    localparam logic [1:0] MODE_FLUSH   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    typedef struct packed {
        logic take_in;
        logic load_word;
    } cmd_t;

    typedef struct packed {
        logic in_flush;
        logic pending;
    } status_t;

    typedef struct packed {
        logic [12:0] on_count;
        logic [12:0] off_count;
    } enc_t;

    // Map a clamped duty and a phase to an on/off tick pair.
    function automatic enc_t encode(logic [11:0] phase, logic [11:0] d);
        enc_t e;
        if (d == 12'd0)
        begin
            e.on_count  = 13'd0;
            e.off_count = FULL_FLAG;
        end
        else if (d == DUTY_MAX)
        begin
            e.on_count  = FULL_FLAG;
            e.off_count = 13'd0;
        end
        else
        begin
            e.on_count  = {1'b0, phase};
            e.off_count = {1'b0, 12'(phase + d)};
        end
        return e;
    endfunction

endpackage

// ===== rtl/psdf_if.sv =====
// Request and write channel interfaces of the PWM shadow duty block.
// Depends on psdf_pkg.
interface psdf_req_if import psdf_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  channel;
    logic [15:0] duty;

    modport source (output valid, mode, channel, duty, input ready);
    modport sink   (input valid, mode, channel, duty, output ready);
endinterface

interface psdf_rsp_if import psdf_pkg::*;;
    logic        valid;
    logic        ready;
    logic        broadcast;
    logic [3:0]  target_channel;
    logic [12:0] on_count;
    logic [12:0] off_count;
    logic        last;

    modport source (output valid, broadcast, target_channel, on_count, off_count, last,
                    input ready);
    modport sink   (input valid, broadcast, target_channel, on_count, off_count, last,
                    output ready);
endinterface

// ===== rtl/pwm_shadow_duty_flush_top.sv =====
// Shadow store of per-channel PWM duties with a dirty mask; a flush word sends
// the pending broadcast write and then one write per dirty channel, lowest
// first, each as an on/off tick pair, the final one marked last. A set or
// set-all word is taken in ST_IDLE. A flush holds req.ready low as it steps
// through ST_LOAD and ST_WAIT: ST_LOAD loads the broadcast write, else the
// lowest dirty channel, into the single output register; ST_WAIT holds it
// on rsp until rsp.ready; a last ST_LOAD finds nothing left. Only one word is in
// work at a time. Depends on psdf_pkg, psdf_if, psdf_ctrl and psdf_dpath.
module pwm_shadow_duty_flush_top import psdf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    psdf_req_if.sink   req,
    psdf_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    psdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid)
    );

    psdf_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (req.mode),
        .channel        (req.channel),
        .duty           (req.duty),
        .cmd            (cmd),
        .status         (status),
        .broadcast      (rsp.broadcast),
        .target_channel (rsp.target_channel),
        .on_count       (rsp.on_count),
        .off_count      (rsp.off_count),
        .last           (rsp.last)
    );

endmodule

// ===== rtl/psdf_ctrl.sv =====
// Controller of the PWM shadow duty block: takes words, steps a flush.
// Depends on psdf_pkg.
module psdf_ctrl import psdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_ready,
    output logic    out_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.take_in   = 1'b0;
        cmd.load_word = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_in = in_valid;
                if (in_valid && status.in_flush)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Load the next pending write, or finish the flush.
                if (status.pending)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = ST_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_WAIT);

endmodule

// ===== rtl/psdf_dpath.sv =====
// Datapath of the PWM shadow duty block: duty store, dirty mask, output word.
// Depends on psdf_pkg.
module psdf_dpath import psdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  mode,
    input  logic [7:0]  channel,
    input  logic [15:0] duty,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        broadcast,
    output logic [3:0]  target_channel,
    output logic [12:0] on_count,
    output logic [12:0] off_count,
    output logic        last
);

    logic [11:0]         duty_reg [CHANNELS];
    logic [11:0]         duty_next [CHANNELS];
    logic [CHANNELS-1:0] dirty_reg;
    logic [CHANNELS-1:0] dirty_next;
    logic                bc_pend_reg;
    logic                bc_pend_next;
    logic [11:0]         bc_duty_reg;
    logic [11:0]         bc_duty_next;

    logic                out_bc_reg;
    logic [3:0]          out_chan_reg;
    logic [12:0]         out_on_reg;
    logic [12:0]         out_off_reg;
    logic                out_last_reg;

    logic [11:0]         duty_clamped;
    logic                chan_ok;
    logic [CHAN_W-1:0]   chan_idx;
    logic [CHAN_W-1:0]   scan_idx;
    logic [CHANNELS-1:0] scan_bit;
    logic [11:0]         scan_phase;
    enc_t                enc_bc;
    enc_t                enc_ch;

    assign duty_clamped = (duty > {4'd0, DUTY_MAX}) ? DUTY_MAX : duty[11:0];
    assign chan_ok      = ({1'b0, channel} < 9'(CHANNELS));
    assign chan_idx     = channel[CHAN_W-1:0];

    // Lowest dirty channel.
    always_comb
    begin
        scan_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (dirty_reg[i])
            begin
                scan_idx = CHAN_W'(i);
            end
        end
    end

    assign scan_bit   = CHANNELS'(1) << scan_idx;
    assign scan_phase = 12'(32'(scan_idx) * PHASE_STEP);
    assign enc_bc     = encode(12'd0, bc_duty_reg);
    assign enc_ch     = encode(scan_phase, duty_reg[scan_idx]);

    always_comb
    begin
        duty_next    = duty_reg;
        dirty_next   = dirty_reg;
        bc_pend_next = bc_pend_reg;
        bc_duty_next = bc_duty_reg;
        if (cmd.take_in)
        begin
            case (mode)
                MODE_SET:
                begin
                    if (chan_ok)
                    begin
                        duty_next[chan_idx]  = duty_clamped;
                        dirty_next[chan_idx] = 1'b1;
                    end
                end
                MODE_SET_ALL:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        duty_next[i] = duty_clamped;
                    end
                    dirty_next   = '0;
                    bc_pend_next = 1'b1;
                    bc_duty_next = duty_clamped;
                end
                default:
                begin
                    // Flush and the unused code change no state here.
                end
            endcase
        end
        else if (cmd.load_word)
        begin
            if (bc_pend_reg)
            begin
                bc_pend_next = 1'b0;
            end
            else
            begin
                dirty_next = dirty_reg & ~scan_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i] <= '0;
            end
            dirty_reg   <= '0;
            bc_pend_reg <= 1'b0;
            bc_duty_reg <= '0;
        end
        else
        begin
            duty_reg    <= duty_next;
            dirty_reg   <= dirty_next;
            bc_pend_reg <= bc_pend_next;
            bc_duty_reg <= bc_duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            if (bc_pend_reg)
            begin
                out_bc_reg   <= 1'b1;
                out_chan_reg <= 4'd0;
                out_on_reg   <= enc_bc.on_count;
                out_off_reg  <= enc_bc.off_count;
                out_last_reg <= (dirty_reg == '0);
            end
            else
            begin
                out_bc_reg   <= 1'b0;
                out_chan_reg <= 4'(scan_idx);
                out_on_reg   <= enc_ch.on_count;
                out_off_reg  <= enc_ch.off_count;
                out_last_reg <= ((dirty_reg & ~scan_bit) == '0);
            end
        end
    end

    assign status.in_flush = (mode == MODE_FLUSH);
    assign status.pending  = bc_pend_reg | (|dirty_reg);

    assign broadcast      = out_bc_reg;
    assign target_channel = out_chan_reg;
    assign on_count       = out_on_reg;
    assign off_count      = out_off_reg;
    assign last           = out_last_reg;

endmodule

// ===== rtl/psdf_checker.sv =====
// Port-level checks of the PWM shadow duty block, bound to the top level.
// Depends on pwm_shadow_duty_flush_top_assert.svh.
`include "pwm_shadow_duty_flush_top_assert.svh"

module psdf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_broadcast,
    input logic [3:0]  rsp_target_channel,
    input logic [12:0] rsp_on_count,
    input logic [12:0] rsp_off_count
);

    `PSDF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
    `PSDF_ASSERT_NOW(a_one_word, clk, rst_n, rsp_valid, !req_ready, "req taken during flush")
    `PSDF_ASSERT_NOW(a_bc_chan, clk, rst_n, rsp_valid && rsp_broadcast, rsp_target_channel == 4'd0, "broadcast channel")
    `PSDF_ASSERT_NOW(a_full_on, clk, rst_n, rsp_valid && rsp_on_count[12], rsp_on_count[11:0] == 12'd0 && rsp_off_count == 13'd0, "full on")

endmodule

bind pwm_shadow_duty_flush_top psdf_checker u_psdf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_broadcast      (rsp.broadcast),
    .rsp_target_channel (rsp.target_channel),
    .rsp_on_count       (rsp.on_count),
    .rsp_off_count      (rsp.off_count)
);

// ===== bench/tb_pwm_shadow_duty_flush_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pwm_shadow_duty_flush_top: drives request words with
// random gaps, predicts every flush write and checks it on the write channel.
// Depends on psdf_pkg, psdf_if and the block's RTL.
module tb_pwm_shadow_duty_flush_top;
    import psdf_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 150;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 300;
    localparam longint     TIMEOUT_NS   = 20_000_000;

    typedef struct packed {
        logic        broadcast;
        logic [3:0]  target_channel;
        logic [12:0] on_count;
        logic [12:0] off_count;
        logic        last;
    } write_t;

    logic clk;
    logic rst_n;

    psdf_req_if req ();
    psdf_rsp_if rsp ();

    pwm_shadow_duty_flush_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the block's state
    logic [11:0] shadow_duty [CHANNELS];
    logic [CHANNELS-1:0] dirty;
    logic        bcast_pending;
    logic [11:0] bcast_duty;

    write_t pending_writes [$];
    int     mismatch_count;
    int     words_sent;
    bit     src_idle_on;
    bit     snk_idle_on;
    int     sink_hold;
    int     sink_gap;

    // Start low so the first rising edge comes after time zero.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic write_t tick_pair(logic bc, int ch, logic [11:0] d);
        write_t w;
        logic [11:0] phase;
        phase = 12'(ch * (4096 / CHANNELS));
        w.broadcast      = bc;
        w.target_channel = 4'(ch);
        w.last           = 1'b0;
        if (d == 12'd0)
        begin
            w.on_count  = 13'd0;
            w.off_count = 13'd4096;
        end
        else if (d == 12'hFFF)
        begin
            w.on_count  = 13'd4096;
            w.off_count = 13'd0;
        end
        else
        begin
            w.on_count  = {1'b0, phase};
            w.off_count = {1'b0, 12'(phase + d)};
        end
        return w;
    endfunction

    // Update the shadow state for one accepted word and queue its writes.
    task automatic apply_word(logic [1:0] mode, logic [7:0] channel, logic [15:0] duty);
        logic [11:0] d;
        write_t held;
        bit     have_held;
        d = (duty > 16'd4095) ? 12'hFFF : duty[11:0];
        have_held = 1'b0;
        held = '0;
        case (mode)
            MODE_SET:
            begin
                if (channel < CHANNELS)
                begin
                    shadow_duty[channel] = d;
                    dirty[channel] = 1'b1;
                end
            end
            MODE_SET_ALL:
            begin
                for (int i = 0; i < CHANNELS; i++)
                    shadow_duty[i] = d;
                dirty = '0;
                bcast_pending = 1'b1;
                bcast_duty = d;
            end
            MODE_FLUSH:
            begin
                if (bcast_pending)
                begin
                    held = tick_pair(1'b1, 0, bcast_duty);
                    have_held = 1'b1;
                    bcast_pending = 1'b0;
                end
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (dirty[i])
                    begin
                        if (have_held)
                            pending_writes.push_back(held);
                        held = tick_pair(1'b0, i, shadow_duty[i]);
                        have_held = 1'b1;
                        dirty[i] = 1'b0;
                    end
                end
                // hold back the final write so it can carry the last flag
                if (have_held)
                begin
                    held.last = 1'b1;
                    pending_writes.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic offer_word(logic [1:0] mode, logic [7:0] channel, logic [15:0] duty);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.mode    <= mode;
        req.channel <= channel;
        req.duty    <= duty;
        do
            @(posedge clk);
        while (!req.ready);
        apply_word(mode, channel, duty);
        if (!(mode == MODE_UNUSED || (mode == MODE_SET && channel >= CHANNELS)))
            words_sent++;
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [12:0] expv, logic [12:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
            mismatch_count++;
        end
    endtask

    // Write channel checker
    initial
    begin
        write_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $display("%0t: unexpected write: expected none, actual bc=%0d ch=%0d on=%0d off=%0d",
                             $time, rsp.broadcast, rsp.target_channel, rsp.on_count,
                             rsp.off_count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    check_field("broadcast", 13'(want.broadcast), 13'(rsp.broadcast));
                    check_field("target_channel", 13'(want.target_channel),
                                13'(rsp.target_channel));
                    check_field("on_count", want.on_count, rsp.on_count);
                    check_field("off_count", want.off_count, rsp.off_count);
                    check_field("last", 13'(want.last), 13'(rsp.last));
                end
            end
        end
    end

    // Write channel receiver: random stalls plus a long hold-off on request
    initial
    begin
        rsp.ready <= 1'b0;
        sink_gap = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                rsp.ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gap > 0)
            begin
                rsp.ready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (snk_idle_on && $urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[pwm_shadow_duty_flush_top] ERROR");
        $finish;
    end

    // Flush with nothing pending right after reset: no write may appear.
    task automatic test_empty_flush();
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        wait_drain();
    endtask

    task automatic test_directed();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        offer_word(MODE_SET, 8'd0, 16'd0);
        offer_word(MODE_SET, 8'd15, 16'hFFFF);
        offer_word(MODE_SET, 8'd7, 16'd4095);
        offer_word(MODE_SET, 8'd1, 16'd4094);
        offer_word(MODE_SET, 8'd2, 16'd1);
        offer_word(MODE_SET, 8'd14, 16'd4096);
        offer_word(MODE_SET, 8'd16, 16'd1234);
        offer_word(MODE_SET, 8'd255, 16'hAAAA);
        offer_word(MODE_UNUSED, 8'h55, 16'h5555);
        offer_word(MODE_FLUSH, 8'hFF, 16'hFFFF);
        offer_word(MODE_SET_ALL, 8'd3, 16'h1234);
        offer_word(MODE_SET, 8'd3, 16'd100);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_SET_ALL, 8'd0, 16'd0);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_SET_ALL, 8'd0, 16'd1);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_SET_ALL, 8'd0, 16'd4094);
        offer_word(MODE_SET, 8'd8, 16'd2000);
        offer_word(MODE_SET, 8'd8, 16'd3000);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        wait_drain();
    endtask

    // Fill every channel, then stall the write side while words keep coming.
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        offer_word(MODE_SET_ALL, 8'd0, 16'd2048);
        for (int i = 0; i < CHANNELS; i++)
            offer_word(MODE_SET, 8'(i), 16'(i * 300 + 1));
        sink_hold = HOLD_CYCLES;
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_SET, 8'd4, 16'd4095);
        offer_word(MODE_SET, 8'd9, 16'd0);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        offer_word(MODE_SET, 8'd12, 16'd77);
        offer_word(MODE_FLUSH, 8'd0, 16'd0);
        wait_drain();
    endtask

    function automatic logic [15:0] rand_duty();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd4095;
            2: return 16'($urandom_range(4096, 65535));
            3: return 16'($urandom_range(1, 3));
            4: return 16'($urandom_range(4092, 4094));
            default: return 16'($urandom_range(1, 4094));
        endcase
    endfunction

    // Random set bursts closed by a flush, with some noise mixed in.
    task automatic test_random();
        int burst;
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0)
                offer_word(MODE_SET_ALL, 8'($urandom_range(0, 255)), rand_duty());
            burst = $urandom_range(0, 7);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 19))
                    0: offer_word(MODE_UNUSED, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                    1: offer_word(MODE_SET, 8'($urandom_range(CHANNELS, 255)), rand_duty());
                    2: offer_word(MODE_SET_ALL, 8'($urandom_range(0, 255)), rand_duty());
                    3: offer_word(MODE_FLUSH, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                    default: offer_word(MODE_SET, 8'($urandom_range(0, CHANNELS - 1)),
                                        rand_duty());
                endcase
            end
            offer_word(MODE_FLUSH, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.mode      <= MODE_SET;
        req.channel   <= 8'd0;
        req.duty      <= 16'd0;
        shadow_duty    = '{default: 12'd0};
        dirty          = '0;
        bcast_pending  = 1'b0;
        bcast_duty     = 12'd0;
        mismatch_count = 0;
        words_sent     = 0;
        sink_hold      = 0;
        src_idle_on    = 1'b0;
        snk_idle_on    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_flush();
        test_directed();
        test_backpressure();
        test_random();

        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("[pwm_shadow_duty_flush_top] OK");
        else
            $display("[pwm_shadow_duty_flush_top] ERROR");
        $finish;
    end

endmodule
